// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the receiver checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsr assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsr assertion failed");

`endif

// File: hw/rtl/wsr_pkg.sv
// ----------------------------------------------------------------------------
// wsr_pkg
// Types and constants shared by the text frame receiver modules.
// ----------------------------------------------------------------------------
package wsr_pkg;

    localparam int unsigned CAP_W = 17;
    localparam int unsigned LEN_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;

    // frame opcodes (low nibble of first header byte)
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // 7-bit length escape codes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [1:0] {
        EV_DATA   = 2'd0,
        EV_EMPTY  = 2'd1,
        EV_CLOSED = 2'd2,
        EV_ERROR  = 2'd3
    } event_t;

    typedef enum logic [9:0] {
        PH_HDR0    = 10'b00_0000_0001,
        PH_HDR1    = 10'b00_0000_0010,
        PH_EXT_HI  = 10'b00_0000_0100,
        PH_EXT_LO  = 10'b00_0000_1000,
        PH_KEY0    = 10'b00_0001_0000,
        PH_KEY1    = 10'b00_0010_0000,
        PH_KEY2    = 10'b00_0100_0000,
        PH_KEY3    = 10'b00_1000_0000,
        PH_PAYLOAD = 10'b01_0000_0000,
        PH_HALT    = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        event_t     ev;
    } result_t;

endpackage

// File: hw/rtl/wsr_parse.sv
// ----------------------------------------------------------------------------
// wsr_parse
// Frame header parser and payload unmasker, one byte per accepted request.
// ----------------------------------------------------------------------------
module wsr_parse import wsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic [CAP_W-1:0] capacity,
    output logic             res_valid,
    output result_t          res
);

    phase_t           phase_reg,  phase_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             ping_reg,   ping_next;
    logic             masked_reg, masked_next;
    logic [LEN_W-1:0] len_reg,    len_next;
    logic [LEN_W-1:0] idx_reg,    idx_next;
    logic [31:0]      key_reg,    key_next;

    logic             finish_len;
    logic             hdr_done;
    logic             masked_v;
    logic [LEN_W-1:0] idx_inc;
    logic [7:0]       key_byte;
    logic             last_v;

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        ping_next   = ping_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        res_valid   = 1'b0;
        res         = '{data: 8'h00, last: 1'b1, ev: EV_DATA};
        finish_len  = 1'b0;
        hdr_done    = 1'b0;
        masked_v    = masked_reg;
        idx_inc     = idx_reg + 16'd1;
        last_v      = (idx_inc >= len_reg);

        case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (opcode_reg == OP_CLOSE)
                    begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res.ev     = EV_CLOSED;
                    end
                    else if (opcode_reg != OP_PING && opcode_reg != OP_TEXT)
                    begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res.ev     = EV_ERROR;
                    end
                    else
                    begin
                        ping_next   = (opcode_reg == OP_PING);
                        masked_next = rx_byte[7];
                        masked_v    = rx_byte[7];
                        if (rx_byte[6:0] == LEN_EXT64)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res.ev     = EV_ERROR;
                        end
                        else if (rx_byte[6:0] == LEN_EXT16)
                        begin
                            len_next   = '0;
                            phase_next = PH_EXT_HI;
                        end
                        else
                        begin
                            len_next   = {9'd0, rx_byte[6:0]};
                            finish_len = 1'b1;
                        end
                    end
                end
                PH_EXT_HI:
                begin
                    len_next   = {rx_byte, 8'h00};
                    phase_next = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    len_next   = {len_reg[15:8], rx_byte};
                    finish_len = 1'b1;
                end
                PH_KEY0:
                begin
                    key_next   = {key_reg[23:0], rx_byte};
                    phase_next = PH_KEY1;
                end
                PH_KEY1:
                begin
                    key_next   = {key_reg[23:0], rx_byte};
                    phase_next = PH_KEY2;
                end
                PH_KEY2:
                begin
                    key_next   = {key_reg[23:0], rx_byte};
                    phase_next = PH_KEY3;
                end
                PH_KEY3:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    hdr_done = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    idx_next = idx_inc;
                    if (last_v)
                    begin
                        phase_next = PH_HDR0;
                    end
                    if (!ping_reg)
                    begin
                        res_valid = 1'b1;
                        res.data  = rx_byte ^ (masked_reg ? key_byte : 8'h00);
                        res.last  = last_v;
                        res.ev    = EV_DATA;
                    end
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase

            // length known: key bytes follow, or the header is complete
            if (finish_len)
            begin
                if (masked_v)
                begin
                    key_next   = '0;
                    phase_next = PH_KEY0;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done)
            begin
                if (!ping_next && (({1'b0, len_next} + 17'd1) > capacity))
                begin
                    phase_next = PH_HALT;
                    res_valid  = 1'b1;
                    res.ev     = EV_ERROR;
                end
                else if (len_next == '0)
                begin
                    // empty text frame is reported, empty ping is silent
                    phase_next = PH_HDR0;
                    if (!ping_next)
                    begin
                        res_valid = 1'b1;
                        res.ev    = EV_EMPTY;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            ping_reg   <= 1'b0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            idx_reg    <= '0;
            key_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            ping_reg   <= ping_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            key_reg    <= key_next;
        end
    end

endmodule

// File: hw/rtl/wsr_outbuf.sv
// ----------------------------------------------------------------------------
// wsr_outbuf
// Result register with one skid entry; stalls the input only when full.
// ----------------------------------------------------------------------------
module wsr_outbuf import wsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    input  logic    out_stall,
    output logic    full,
    output logic    out_valid,
    output result_t out_res
);

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    can_load;

    assign can_load  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            // skid is only ever filled while the output is stalled
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

endmodule

// File: hw/rtl/websocket_text_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_text_frame_receiver
// Takes a WebSocket byte stream one byte per cycle while in_stall is low and
// delivers unmasked text payload plus empty-frame, close and error events.
//
// Each accepted byte is processed in the cycle it is accepted and any result
// lands in an output register, so the block sustains one byte per clock while
// the consumer keeps up. The only thing that stalls the input is the output
// side: a result register plus a one-entry skid let one more result in after
// the consumer stalls, and after that in_stall rises until the consumer takes
// a result. Header and mask key bytes give only event results, ping payload
// bytes none. A close frame, an unknown opcode, a 64-bit length or a text
// payload with length + 1 > buffer_capacity emits a single close or error
// event and then the block swallows all input until reset. buffer_capacity
// (reset 4096) is written through cfg_wr_en / cfg_wr_data and should only
// change while no frame is in progress.
// ----------------------------------------------------------------------------
module websocket_text_frame_receiver import wsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    // configuration: buffer capacity
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,

    // byte request channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,

    // result request channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       payload_byte,
    output logic             last_of_frame,
    output logic [1:0]       event_res
);

    logic [CAP_W-1:0] capacity_reg;
    logic             accept;
    logic             res_valid;
    result_t          res;
    result_t          out_res;

    // capacity register, write only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    assign accept = in_valid && !in_stall;

    // header parse, length/capacity check, unmask
    wsr_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .capacity  (capacity_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register + skid; in_stall only when skid holds a request
    wsr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign payload_byte  = out_res.data;
    assign last_of_frame = out_res.last;
    assign event_res     = out_res.ev;

endmodule

// File: hw/rtl/wsr_checker.sv
// ----------------------------------------------------------------------------
// wsr_checker
// Port-level checks for the text frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsr_checker import wsr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [7:0]       payload_byte,
    input logic             last_of_frame,
    input logic [1:0]       event_res
);

    logic halted_reg;
    logic is_event;

    assign is_event = (event_res != EV_DATA);

    // set once a close or error event has been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg <= 1'b0;
        end
        else if (out_valid && !out_stall &&
                 (event_res == EV_CLOSED || event_res == EV_ERROR))
        begin
            halted_reg <= 1'b1;
        end
    end

    `WSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `WSR_ASSERT_IMPL(a_event_last, out_valid && is_event, last_of_frame)
    `WSR_ASSERT_IMPL(a_event_zero, out_valid && is_event, payload_byte == 8'h00)
    `WSR_ASSERT_IMPL(a_halt_silent, halted_reg, !out_valid)

endmodule

bind websocket_text_frame_receiver wsr_checker u_wsr_checker (.*);

// File: tb/tb_websocket_text_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_text_frame_receiver
// Self-checking bench for the WebSocket text frame receiver. A table of
// hand-picked bytes runs first, then one long masked text frame with a 16-bit
// length, then random well-formed text and ping frames under several buffer
// capacities, and finally one frame that halts the block (close, bad opcode,
// 64-bit length or capacity overflow, picked at random). Every accepted byte
// goes through a local deframer that predicts the result requests; the output
// monitor compares each result request against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_websocket_text_frame_receiver import wsr_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 760;
    localparam int unsigned REPORT_MAX   = 10;

    // how a row of the directed table is checked
    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,     // result taken from the local deframer
        ROW_SILENT  = 2'd1,     // no result may follow this byte
        ROW_FIXED   = 2'd2      // result typed into the table
    } row_check_t;

    typedef struct packed {
        logic [7:0] b;
        row_check_t chk;
        result_t    res;
    } stim_row_t;

    localparam int unsigned DIRECTED_LEN = 25;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // empty text frame, unmasked: one event on the length byte
        '{8'h81, ROW_SILENT, '0},
        '{8'h00, ROW_FIXED,  '{8'h00, 1'b1, EV_EMPTY}},
        // unmasked text, two bytes at the extremes of the byte range
        '{8'h81, ROW_SILENT, '0},
        '{8'h02, ROW_SILENT, '0},
        '{8'h00, ROW_FIXED,  '{8'h00, 1'b0, EV_DATA}},
        '{8'hff, ROW_FIXED,  '{8'hff, 1'b1, EV_DATA}},
        // masked text of three bytes; FIN clear and RSV bits set, all ignored
        '{8'h71, ROW_SILENT, '0},
        '{8'h83, ROW_SILENT, '0},
        '{8'hde, ROW_SILENT, '0},
        '{8'had, ROW_SILENT, '0},
        '{8'hbe, ROW_SILENT, '0},
        '{8'hef, ROW_SILENT, '0},
        '{8'h41, ROW_PREDICT, '0},
        '{8'h42, ROW_PREDICT, '0},
        '{8'h43, ROW_PREDICT, '0},
        // one-byte ping, payload dropped
        '{8'h89, ROW_SILENT, '0},
        '{8'h01, ROW_SILENT, '0},
        '{8'h5a, ROW_SILENT, '0},
        // empty ping gives nothing at all
        '{8'h89, ROW_SILENT, '0},
        '{8'h00, ROW_SILENT, '0},
        // 16-bit extended length of one
        '{8'h81, ROW_SILENT, '0},
        '{8'h7e, ROW_SILENT, '0},
        '{8'h00, ROW_SILENT, '0},
        '{8'h01, ROW_SILENT, '0},
        '{8'h80, ROW_FIXED,  '{8'h80, 1'b1, EV_DATA}}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       rx_byte;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       payload_byte;
    logic             last_of_frame;
    logic [1:0]       event_res;

    // deframer state, kept in step with every accepted byte
    phase_t           ph;
    logic [3:0]       opc;
    logic             is_ping;
    logic             masked;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] bidx;
    logic [31:0]      key;
    logic [CAP_W-1:0] capacity;

    result_t          awaited_results [$];
    int unsigned      fail_count;
    int unsigned      bytes_sent;
    int unsigned      cycle_count;

    // when set, that side runs without idle cycles for the current frame
    bit               quiet_in;
    bit               quiet_out;

    websocket_text_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .event_res     (event_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned idle_cycles(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // ------------------------------------------------------------------------
    // Deframer: same parse as the block, one byte at a time
    // ------------------------------------------------------------------------

    // length and key are known: payload, or for text an empty event or error
    task automatic finish_header(output bit produced, output result_t r);
        produced = 1'b0;
        r        = '0;
        if (!is_ping)
        begin
            // capacity must exceed the length by at least one
            if ({1'b0, plen} + 17'd1 > capacity)
            begin
                ph       = PH_HALT;
                produced = 1'b1;
                r        = '{8'h00, 1'b1, EV_ERROR};
            end
            else if (plen == '0)
            begin
                ph       = PH_HDR0;
                produced = 1'b1;
                r        = '{8'h00, 1'b1, EV_EMPTY};
            end
            else
            begin
                bidx = '0;
                ph   = PH_PAYLOAD;
            end
        end
        else if (plen == '0)
        begin
            ph = PH_HDR0;
        end
        else
        begin
            bidx = '0;
            ph   = PH_PAYLOAD;
        end
    endtask

    task automatic length_known(output bit produced, output result_t r);
        produced = 1'b0;
        r        = '0;
        if (masked)
        begin
            key = '0;
            ph  = PH_KEY0;
        end
        else
        begin
            finish_header(produced, r);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, output bit produced,
                                output result_t r);
        logic [7:0] kb;
        logic       last;
        produced = 1'b0;
        r        = '0;
        case (ph)
            PH_HDR0:
            begin
                opc = b[3:0];
                ph  = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (opc == OP_CLOSE)
                begin
                    ph       = PH_HALT;
                    produced = 1'b1;
                    r        = '{8'h00, 1'b1, EV_CLOSED};
                end
                else if (opc != OP_PING && opc != OP_TEXT)
                begin
                    ph       = PH_HALT;
                    produced = 1'b1;
                    r        = '{8'h00, 1'b1, EV_ERROR};
                end
                else
                begin
                    is_ping = (opc == OP_PING);
                    masked  = b[7];
                    if (b[6:0] == LEN_EXT64)
                    begin
                        ph       = PH_HALT;
                        produced = 1'b1;
                        r        = '{8'h00, 1'b1, EV_ERROR};
                    end
                    else if (b[6:0] == LEN_EXT16)
                    begin
                        plen = '0;
                        ph   = PH_EXT_HI;
                    end
                    else
                    begin
                        plen = {9'd0, b[6:0]};
                        length_known(produced, r);
                    end
                end
            end
            PH_EXT_HI:
            begin
                plen = {b, 8'h00};
                ph   = PH_EXT_LO;
            end
            PH_EXT_LO:
            begin
                plen = plen | {8'h00, b};
                length_known(produced, r);
            end
            PH_KEY0:
            begin
                key = {key[23:0], b};
                ph  = PH_KEY1;
            end
            PH_KEY1:
            begin
                key = {key[23:0], b};
                ph  = PH_KEY2;
            end
            PH_KEY2:
            begin
                key = {key[23:0], b};
                ph  = PH_KEY3;
            end
            PH_KEY3:
            begin
                key = {key[23:0], b};
                finish_header(produced, r);
            end
            PH_PAYLOAD:
            begin
                // first key byte sits in the top of the key word
                kb   = masked ? key[8 * (3 - bidx[1:0]) +: 8] : 8'h00;
                bidx = bidx + 16'd1;
                last = (bidx >= plen);
                if (last)
                    ph = PH_HDR0;
                if (!is_ping)
                begin
                    produced = 1'b1;
                    r        = '{b ^ kb, last, EV_DATA};
                end
            end
            default:
                ph = PH_HALT;   // halted: swallow everything
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one byte request after a random gap and hold it until taken.
    // The prediction is queued at the accepting edge.
    task automatic send_byte(input logic [7:0] b, input row_check_t chk,
                             input result_t fixed);
        int unsigned gap;
        bit          produced;
        result_t     r;
        gap = idle_cycles(quiet_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        deframe_byte(b, produced, r);
        case (chk)
            ROW_PREDICT: if (produced) awaited_results.push_back(r);
            ROW_FIXED:   awaited_results.push_back(fixed);
            default:     ;
        endcase
    endtask

    // Whole frame with random flag bits, key and payload. The extended
    // length form may be used even for short lengths.
    task automatic send_frame(input logic [3:0] op, input bit mask_on,
                              input int unsigned len, input bit ext,
                              input bit rush);
        logic [15:0] l16;
        l16       = len[15:0];
        quiet_in  = rush || ($urandom_range(0, 3) == 0);
        quiet_out = rush || ($urandom_range(0, 3) == 0);
        send_byte({4'($urandom_range(0, 15)), op}, ROW_PREDICT, '0);
        if (ext)
        begin
            send_byte({mask_on, LEN_EXT16}, ROW_PREDICT, '0);
            send_byte(l16[15:8], ROW_PREDICT, '0);
            send_byte(l16[7:0], ROW_PREDICT, '0);
        end
        else
        begin
            send_byte({mask_on, l16[6:0]}, ROW_PREDICT, '0);
        end
        if (mask_on)
            repeat (4) send_byte(8'($urandom), ROW_PREDICT, '0);
        repeat (len) send_byte(8'($urandom), ROW_PREDICT, '0);
    endtask

    // Drop valid, let every predicted result drain, then wait further so a ping
    // or header tail can settle inside the block.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity    = v;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, then check each accepted result request
    // ------------------------------------------------------------------------
    initial
    begin : result_monitor
        int unsigned stall;
        result_t     want;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = idle_cycles(quiet_out);
            if (stall > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
            if (awaited_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: data %02h last %0d event %0d",
                             payload_byte, last_of_frame, event_res);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (payload_byte !== want.data || last_of_frame !== want.last ||
                    event_res !== want.ev)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"result mismatch: got data %02h last %0d event %0d,",
                                  " want data %02h last %0d event %0d"},
                                 payload_byte, last_of_frame, event_res,
                                 want.data, want.last, want.ev);
                end
            end
        end
    end

    // hard stop if the block hangs
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("websocket_text_frame_receiver test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned      rand_start;
        int unsigned      target;
        int unsigned      phase_no;
        int unsigned      kind_sel;
        int unsigned      len_sel;
        int unsigned      flen;
        int unsigned      halt_kind;
        int unsigned      halt_len;
        bit               ping_sel;
        bit               mask_sel;
        logic [3:0]       bad_opc;
        logic [CAP_W-1:0] new_cap;

        in_valid    <= 1'b0;
        rx_byte     <= 8'h00;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        rst_n       <= 1'b0;
        fail_count  = 0;
        bytes_sent  = 0;
        quiet_in    = 1'b0;
        quiet_out   = 1'b0;

        ph       = PH_HDR0;
        opc      = '0;
        is_ping  = 1'b0;
        masked   = 1'b0;
        plen     = '0;
        bidx     = '0;
        key      = '0;
        capacity = CAP_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hand-picked frames at the reset capacity
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].res);

        // long frame at capacity 65536, both extended length bytes set
        wait_idle();
        write_capacity(17'h10000);
        send_frame(OP_TEXT, 1'b1, 300, 1'b1, 1'b1);

        // random frames, a new capacity for each stretch, extremes first
        rand_start = bytes_sent;
        phase_no   = 0;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            case (phase_no)
                0:       new_cap = 17'd1;
                1:       new_cap = 17'h10000;
                default:
                    case ($urandom_range(0, 2))
                        0:       new_cap = 17'($urandom_range(1, 65536));
                        1:       new_cap = 17'($urandom_range(2, 40));
                        default: new_cap = CAP_RESET;
                    endcase
            endcase
            wait_idle();
            write_capacity(new_cap);
            target = bytes_sent + $urandom_range(120, 200);
            while (bytes_sent < target)
            begin
                kind_sel = $urandom_range(0, 9);
                ping_sel = (kind_sel < 2);
                mask_sel = 1'($urandom_range(0, 1));
                len_sel  = $urandom_range(0, 9);
                if (len_sel < 2)
                    flen = 0;
                else if (len_sel < 7)
                    flen = $urandom_range(1, 12);
                else if (len_sel == 7)
                    flen = $urandom_range(13, 125);
                else
                    flen = $urandom_range(0, 300);
                // text must fit; pings have no limit
                if (!ping_sel && flen + 1 > capacity)
                    flen = capacity - 1;
                send_frame(ping_sel ? OP_PING : OP_TEXT, mask_sel, flen,
                           (flen > 125) || (len_sel >= 8), 1'b0);
            end
            phase_no++;
        end

        // one halting frame; everything after it is swallowed
        wait_idle();
        halt_kind = $urandom_range(0, 3);
        case (halt_kind)
            0:
            begin
                send_byte({4'($urandom_range(0, 15)), OP_CLOSE}, ROW_PREDICT, '0);
                send_byte(8'($urandom), ROW_PREDICT, '0);
            end
            1:
            begin
                // continuation or any other unknown opcode
                do bad_opc = 4'($urandom_range(0, 15));
                while (bad_opc == OP_TEXT || bad_opc == OP_CLOSE || bad_opc == OP_PING);
                send_byte({4'($urandom_range(0, 15)), bad_opc}, ROW_PREDICT, '0);
                send_byte(8'($urandom), ROW_PREDICT, '0);
            end
            2:
            begin
                send_byte({4'($urandom_range(0, 15)),
                           ($urandom_range(0, 1) != 0) ? OP_PING : OP_TEXT},
                          ROW_PREDICT, '0);
                send_byte({1'($urandom_range(0, 1)), LEN_EXT64}, ROW_PREDICT, '0);
            end
            default:
            begin
                new_cap = 17'($urandom_range(1, 300));
                write_capacity(new_cap);
                halt_len = new_cap + $urandom_range(0, 3);
                send_frame(OP_TEXT, 1'($urandom_range(0, 1)), halt_len,
                           (halt_len > 125) || ($urandom_range(0, 1) != 0), 1'b0);
            end
        endcase
        repeat (16) send_byte(8'($urandom), ROW_PREDICT, '0);

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("websocket_text_frame_receiver test passed");
        else
            $display("websocket_text_frame_receiver test failed");
        $finish;
    end

endmodule
